// File: rtl/arp_pkg.sv
// Shared types, widths and codes of the atlas rectangle placer.
package arp_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int MAX_DIM     = 4096;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DIM_W       = $clog2(MAX_DIM) + 1;
    localparam int EXT_W       = DIM_W + 1;
    localparam int POS_W       = 12;
    localparam int HASH_W      = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [DIM_W-1:0] ATLAS_RESET_SIZE = DIM_W'(2048);

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = CFG_IDX_W'(1);

    // Result status codes
    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_REUSED  = 2'd1;
    localparam logic [1:0] ST_NO_ROOM = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // One stored rectangle
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
    } entry_t;

endpackage

// File: rtl/arp_cell.sv
// One cell of the entry ring: holds a stored rectangle and passes it on.
module arp_cell (
    input  logic            clk,
    input  logic            shift_en,
    input  logic            load_en,
    input  arp_pkg::entry_t load_entry,
    input  arp_pkg::entry_t nbr_entry,
    output arp_pkg::entry_t entry
);

    arp_pkg::entry_t entry_reg;
    arp_pkg::entry_t entry_next;

    // Take a new rectangle, else advance from the neighbour, else hold
    always_comb
    begin
        entry_next = entry_reg;
        if (load_en)
        begin
            entry_next = load_entry;
        end
        else if (shift_en)
        begin
            entry_next = nbr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/atlas_rect_placer.sv
// Top level of the atlas rectangle placer: entry ring and search sequencer.
//
//  channel  | handshake                | word
//  ---------+--------------------------+-------------------------------------
//  request  | start, busy              | key_hash, rect_width, rect_height
//  result   | done (one-cycle strobe)  | pos_x, pos_y, status
//  config   | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
//  N = MAX_ENTRIES. Entries sit in a ring of N cells that rotates one place per
//  cycle during a scan; every test looks at the head cell only. A request holds
//  busy for one hash lap and the decide state, then, unless that state ends it,
//  for search steps of a check state, a scan lap and a step state each, the
//  store taking place in the step state of the last step; a step that finds the
//  box past the bottom bound ends in its check state. The number of steps is set
//  by the collisions met on the way. done strobes in the first cycle after busy
//  falls, when the next word may be taken. After reset the table is empty, both
//  bounds are 2048. The result receiver cannot stall; cfg_ready is always high.
module atlas_rect_placer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [arp_pkg::HASH_W-1:0]            key_hash,
    input  logic [arp_pkg::DIM_W-1:0]             rect_width,
    input  logic [arp_pkg::DIM_W-1:0]             rect_height,
    output logic                                  done,
    output logic [arp_pkg::POS_W-1:0]             pos_x,
    output logic [arp_pkg::POS_W-1:0]             pos_y,
    output logic [1:0]                            status,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [arp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [arp_pkg::DIM_W-1:0]             cfg_data
);

    localparam int N     = arp_pkg::MAX_ENTRIES;
    localparam int IDX_W = arp_pkg::IDX_W;
    localparam int CNT_W = arp_pkg::CNT_W;
    localparam int DIM_W = arp_pkg::DIM_W;
    localparam int EXT_W = arp_pkg::EXT_W;
    localparam int POS_W = arp_pkg::POS_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_HASH   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_STEP   = 3'd5;

    localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(arp_pkg::MAX_DIM);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(N - 1);

    // Control state
    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;
    logic              hit_reg, hit_next;
    logic              done_reg, done_next;
    logic [DIM_W-1:0]  atlas_width_reg, atlas_width_next;
    logic [DIM_W-1:0]  atlas_height_reg, atlas_height_next;

    // Payload state
    logic [arp_pkg::HASH_W-1:0] key_reg, key_next;
    logic [DIM_W-1:0]  w_reg, w_next;
    logic [DIM_W-1:0]  h_reg, h_next;
    logic [EXT_W-1:0]  x_reg, x_next;
    logic [EXT_W-1:0]  y_reg, y_next;
    logic [EXT_W-1:0]  ny_reg, ny_next;
    logic [EXT_W-1:0]  hr_reg, hr_next;
    logic [EXT_W-1:0]  hb_reg, hb_next;
    logic [POS_W-1:0]  fx_reg, fx_next;
    logic [POS_W-1:0]  fy_reg, fy_next;
    logic [POS_W-1:0]  pos_x_reg, pos_x_next;
    logic [POS_W-1:0]  pos_y_reg, pos_y_next;
    logic [1:0]        status_reg, status_next;

    // Ring wiring
    arp_pkg::entry_t   cell_entry [N];
    arp_pkg::entry_t   load_entry;
    arp_pkg::entry_t   head;
    logic              shift_en;
    logic              store_en;

    // Datapath terms
    logic [DIM_W-1:0]  bound_w, bound_h;
    logic              head_valid;
    logic [EXT_W-1:0]  head_right, head_bottom;
    logic [EXT_W-1:0]  cand_right, cand_bottom;
    logic              collide;
    logic              size_bad;

    // Build the ring: cell k takes from cell k+1, the last from the head
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        arp_cell u_cell (
            .clk        (clk),
            .shift_en   (shift_en),
            .load_en    (store_en && (count_reg == CNT_W'(k))),
            .load_entry (load_entry),
            .nbr_entry  (cell_entry[(k + 1) % N]),
            .entry      (cell_entry[k])
        );
    end

    assign head = cell_entry[0];

    // Clamp the bounds to the largest atlas
    assign bound_w = (atlas_width_reg  > DIM_LIMIT) ? DIM_LIMIT : atlas_width_reg;
    assign bound_h = (atlas_height_reg > DIM_LIMIT) ? DIM_LIMIT : atlas_height_reg;

    // Test the head entry against the candidate box
    assign head_valid  = CNT_W'(step_reg) < count_reg;
    assign head_right  = EXT_W'(head.x) + EXT_W'(head.w);
    assign head_bottom = EXT_W'(head.y) + EXT_W'(head.h);
    assign cand_right  = x_reg + EXT_W'(w_reg);
    assign cand_bottom = y_reg + EXT_W'(h_reg);
    assign collide     = (head_bottom > y_reg) && (EXT_W'(head.y) < cand_bottom) &&
                         (head_right > x_reg) && (EXT_W'(head.x) < cand_right);

    assign size_bad = (w_reg == '0) || (h_reg == '0) ||
                      (w_reg > DIM_LIMIT) || (h_reg > DIM_LIMIT);

    assign load_entry.hash = key_reg;
    assign load_entry.x    = x_reg[POS_W-1:0];
    assign load_entry.y    = y_reg[POS_W-1:0];
    assign load_entry.w    = w_reg;
    assign load_entry.h    = h_reg;

    // Sequence the hash lap, the search steps and the store
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        count_next        = count_reg;
        found_next        = found_reg;
        hit_next          = hit_reg;
        done_next         = 1'b0;
        atlas_width_next  = atlas_width_reg;
        atlas_height_next = atlas_height_reg;
        key_next          = key_reg;
        w_next            = w_reg;
        h_next            = h_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        ny_next           = ny_reg;
        hr_next           = hr_reg;
        hb_next           = hb_reg;
        fx_next           = fx_reg;
        fy_next           = fy_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        status_next       = status_reg;
        shift_en          = 1'b0;
        store_en          = 1'b0;

        // Take configuration words
        if (cfg_valid)
        begin
            unique case (cfg_index)
                arp_pkg::REG_ATLAS_WIDTH:  atlas_width_next  = cfg_data;
                arp_pkg::REG_ATLAS_HEIGHT: atlas_height_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next   = key_hash;
                    w_next     = rect_width;
                    h_next     = rect_height;
                    found_next = 1'b0;
                    step_next  = '0;
                    state_next = S_HASH;
                end
            end

            S_HASH:
            begin
                shift_en = 1'b1;
                if (head_valid && !found_reg && (head.hash == key_reg))
                begin
                    found_next = 1'b1;
                    fx_next    = head.x;
                    fy_next    = head.y;
                end
                if (step_reg == LAST_IDX)
                begin
                    step_next  = '0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end

            S_DECIDE:
            begin
                x_next  = '0;
                y_next  = '0;
                ny_next = '0;
                if (found_reg)
                begin
                    done_next   = 1'b1;
                    pos_x_next  = fx_reg;
                    pos_y_next  = fy_reg;
                    status_next = arp_pkg::ST_REUSED;
                    state_next  = S_IDLE;
                end
                else if (count_reg >= CNT_W'(N))
                begin
                    done_next   = 1'b1;
                    pos_x_next  = '0;
                    pos_y_next  = '0;
                    status_next = arp_pkg::ST_FULL;
                    state_next  = S_IDLE;
                end
                else if (size_bad)
                begin
                    done_next   = 1'b1;
                    pos_x_next  = '0;
                    pos_y_next  = '0;
                    status_next = arp_pkg::ST_NO_ROOM;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                if (cand_bottom > EXT_W'(bound_h))
                begin
                    done_next   = 1'b1;
                    pos_x_next  = '0;
                    pos_y_next  = '0;
                    status_next = arp_pkg::ST_NO_ROOM;
                    state_next  = S_IDLE;
                end
                else
                begin
                    hit_next   = 1'b0;
                    step_next  = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                shift_en = 1'b1;
                if (head_valid && !hit_reg && collide)
                begin
                    hit_next = 1'b1;
                    hr_next  = head_right;
                    hb_next  = head_bottom;
                end
                if (step_reg == LAST_IDX)
                begin
                    step_next  = '0;
                    state_next = S_STEP;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end

            S_STEP:
            begin
                if (hit_reg)
                begin
                    // Jump past the first colliding entry, track the row floor
                    x_next = hr_reg;
                    if ((ny_reg == y_reg) || (hb_reg < ny_reg))
                    begin
                        ny_next = hb_reg;
                    end
                    state_next = S_CHECK;
                end
                else if (cand_right > EXT_W'(bound_w))
                begin
                    if (ny_reg <= y_reg)
                    begin
                        done_next   = 1'b1;
                        pos_x_next  = '0;
                        pos_y_next  = '0;
                        status_next = arp_pkg::ST_NO_ROOM;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        x_next     = '0;
                        y_next     = ny_reg;
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    // Store the new entry in the first free cell
                    store_en    = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    done_next   = 1'b1;
                    pos_x_next  = x_reg[POS_W-1:0];
                    pos_y_next  = y_reg[POS_W-1:0];
                    status_next = arp_pkg::ST_PLACED;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            count_reg        <= '0;
            found_reg        <= 1'b0;
            hit_reg          <= 1'b0;
            done_reg         <= 1'b0;
            atlas_width_reg  <= arp_pkg::ATLAS_RESET_SIZE;
            atlas_height_reg <= arp_pkg::ATLAS_RESET_SIZE;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            count_reg        <= count_next;
            found_reg        <= found_next;
            hit_reg          <= hit_next;
            done_reg         <= done_next;
            atlas_width_reg  <= atlas_width_next;
            atlas_height_reg <= atlas_height_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        ny_reg     <= ny_next;
        hr_reg     <= hr_next;
        hb_reg     <= hb_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        status_reg <= status_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign status    = status_reg;
    assign cfg_ready = 1'b1;

endmodule

// File: bench/atlas_rect_placer_checker.sv
// Checker for the atlas rectangle placer: mirrors the entry table and checks each result word.
module atlas_rect_placer_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [arp_pkg::HASH_W-1:0]    key_hash,
    input  logic [arp_pkg::DIM_W-1:0]     rect_width,
    input  logic [arp_pkg::DIM_W-1:0]     rect_height,
    input  logic                          done,
    input  logic [arp_pkg::POS_W-1:0]     pos_x,
    input  logic [arp_pkg::POS_W-1:0]     pos_y,
    input  logic [1:0]                    status,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arp_pkg::DIM_W-1:0]     cfg_data,
    output int                            mismatch_count,
    output int                            pending,
    output int                            n_placed,
    output int                            n_reused,
    output int                            n_no_room,
    output int                            n_full
);
    timeunit 1ns;
    timeprecision 1ps;

    // One expected result word
    typedef struct packed {
        logic [arp_pkg::POS_W-1:0] x;
        logic [arp_pkg::POS_W-1:0] y;
        logic [1:0]                st;
    } spot_t;

    spot_t                      expected_spots[$];
    logic [arp_pkg::HASH_W-1:0] tab_hash [arp_pkg::MAX_ENTRIES];
    int unsigned                tab_x [arp_pkg::MAX_ENTRIES];
    int unsigned                tab_y [arp_pkg::MAX_ENTRIES];
    int unsigned                tab_w [arp_pkg::MAX_ENTRIES];
    int unsigned                tab_h [arp_pkg::MAX_ENTRIES];
    int unsigned                stored;
    int unsigned                bound_w = arp_pkg::ATLAS_RESET_SIZE;
    int unsigned                bound_h = arp_pkg::ATLAS_RESET_SIZE;

    function automatic int unsigned clamp_bound(input int unsigned v);
        return (v > arp_pkg::MAX_DIM) ? arp_pkg::MAX_DIM : v;
    endfunction

    // First-fit scan: step right past the first colliding entry, drop to the
    // lowest bottom edge seen in the row once the box overruns the right bound
    function automatic bit find_spot(input int unsigned w, input int unsigned h,
                                     input int unsigned bw, input int unsigned bh,
                                     output int unsigned px, output int unsigned py);
        int unsigned cx;
        int unsigned cy;
        int unsigned next_row;
        int unsigned bottom;
        int unsigned right;
        bit          hit;
        bit          found;
        bit          settled;
        cx       = 0;
        cy       = 0;
        next_row = 0;
        found    = 1'b0;
        settled  = 1'b0;
        px       = 0;
        py       = 0;
        while (!settled) begin
            if (cy + h > bh) begin
                settled = 1'b1;
            end
            else begin
                hit = 1'b0;
                for (int i = 0; i < stored && !hit; i++) begin
                    bottom = tab_y[i] + tab_h[i];
                    right  = tab_x[i] + tab_w[i];
                    if (bottom > cy && tab_y[i] < cy + h && right > cx && tab_x[i] < cx + w) begin
                        hit = 1'b1;
                        cx  = right;
                        if (next_row == cy || bottom < next_row)
                            next_row = bottom;
                    end
                end
                if (!hit) begin
                    if (cx + w > bw) begin
                        if (next_row <= cy) begin
                            settled = 1'b1;
                        end
                        else begin
                            cx = 0;
                            cy = next_row;
                        end
                    end
                    else begin
                        px      = cx;
                        py      = cy;
                        found   = 1'b1;
                        settled = 1'b1;
                    end
                end
            end
        end
        return found;
    endfunction

    // Work out the result of one request and store a new placement
    function automatic spot_t predict_placement(input logic [arp_pkg::HASH_W-1:0] key,
                                                input int unsigned w, input int unsigned h);
        spot_t       res;
        int unsigned px;
        int unsigned py;
        bit          matched;
        res     = '0;
        matched = 1'b0;
        for (int i = 0; i < stored && !matched; i++) begin
            if (tab_hash[i] == key) begin
                matched = 1'b1;
                res.x   = arp_pkg::POS_W'(tab_x[i]);
                res.y   = arp_pkg::POS_W'(tab_y[i]);
                res.st  = arp_pkg::ST_REUSED;
            end
        end
        if (!matched) begin
            if (stored >= arp_pkg::MAX_ENTRIES) begin
                res.st = arp_pkg::ST_FULL;
            end
            else if (w == 0 || h == 0 || w > arp_pkg::MAX_DIM || h > arp_pkg::MAX_DIM ||
                     !find_spot(w, h, clamp_bound(bound_w), clamp_bound(bound_h), px, py)) begin
                res.st = arp_pkg::ST_NO_ROOM;
            end
            else begin
                tab_hash[stored] = key;
                tab_x[stored]    = px;
                tab_y[stored]    = py;
                tab_w[stored]    = w;
                tab_h[stored]    = h;
                stored++;
                res.x  = arp_pkg::POS_W'(px);
                res.y  = arp_pkg::POS_W'(py);
                res.st = arp_pkg::ST_PLACED;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        spot_t want;
        if (!rst_n) begin
            expected_spots.delete();
            stored         = 0;
            bound_w        = arp_pkg::ATLAS_RESET_SIZE;
            bound_h        = arp_pkg::ATLAS_RESET_SIZE;
            mismatch_count = 0;
            pending        = 0;
            n_placed       = 0;
            n_reused       = 0;
            n_no_room      = 0;
            n_full         = 0;
        end
        else begin
            // Take bound register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == arp_pkg::REG_ATLAS_WIDTH)
                    bound_w = cfg_data;
                else if (cfg_index == arp_pkg::REG_ATLAS_HEIGHT)
                    bound_h = cfg_data;
            end

            // Compare each result word with the oldest expectation
            if (done) begin
                if (expected_spots.size() == 0) begin
                    $error("result word x=%0d y=%0d status=%0d with nothing expected",
                           pos_x, pos_y, status);
                    mismatch_count++;
                end
                else begin
                    want = expected_spots.pop_front();
                    if (pos_x !== want.x) begin
                        $error("pos_x: expected %0d, got %0d", want.x, pos_x);
                        mismatch_count++;
                    end
                    if (pos_y !== want.y) begin
                        $error("pos_y: expected %0d, got %0d", want.y, pos_y);
                        mismatch_count++;
                    end
                    if (status !== want.st) begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        mismatch_count++;
                    end
                    case (want.st)
                        arp_pkg::ST_PLACED:  n_placed++;
                        arp_pkg::ST_REUSED:  n_reused++;
                        arp_pkg::ST_NO_ROOM: n_no_room++;
                        default:             n_full++;
                    endcase
                end
            end

            // Predict each accepted request word
            if (start && !busy)
                expected_spots.push_back(predict_placement(key_hash, rect_width, rect_height));
            pending = expected_spots.size();
        end
    end

endmodule

// File: bench/atlas_rect_placer_tb.sv
// Testbench top for the atlas rectangle placer: stimulus, bound settings and verdict.
module atlas_rect_placer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 1_200_000;
    localparam int ITEMS_PER_PHASE = 90;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [arp_pkg::HASH_W-1:0]    key_hash;
    logic [arp_pkg::DIM_W-1:0]     rect_width;
    logic [arp_pkg::DIM_W-1:0]     rect_height;
    logic                          done;
    logic [arp_pkg::POS_W-1:0]     pos_x;
    logic [arp_pkg::POS_W-1:0]     pos_y;
    logic [1:0]                    status;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [arp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [arp_pkg::DIM_W-1:0]     cfg_data;

    int                            mismatch_count;
    int                            pending;
    int                            n_placed;
    int                            n_reused;
    int                            n_no_room;
    int                            n_full;
    int                            send_idle_pct;
    int                            requests_sent;
    int                            bound_writes;
    int                            quiet_cycles;
    logic [arp_pkg::HASH_W-1:0]    seen_keys[$];

    atlas_rect_placer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .key_hash    (key_hash),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .done        (done),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    atlas_rect_placer_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .key_hash       (key_hash),
        .rect_width     (rect_width),
        .rect_height    (rect_height),
        .done           (done),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .n_placed       (n_placed),
        .n_reused       (n_reused),
        .n_no_room      (n_no_room),
        .n_full         (n_full)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Abort if no word moves on any channel for too long
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request word after a random gap and hold it until taken
    task automatic send_request(input logic [arp_pkg::HASH_W-1:0] key, input int unsigned w,
                                input int unsigned h);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        key_hash    <= key;
        rect_width  <= arp_pkg::DIM_W'(w);
        rect_height <= arp_pkg::DIM_W'(h);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        seen_keys.push_back(key);
        requests_sent++;
    endtask

    // Drop start and wait until every expected result word has come back
    task automatic wait_for_quiet();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0 || busy);
        @(posedge clk);
    endtask

    // Write both bounds back to back, holding valid across the pair
    task automatic set_bounds(input int unsigned bw, input int unsigned bh);
        cfg_valid <= 1'b1;
        cfg_index <= arp_pkg::REG_ATLAS_WIDTH;
        cfg_data  <= arp_pkg::DIM_W'(bw);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= arp_pkg::REG_ATLAS_HEIGHT;
        cfg_data  <= arp_pkg::DIM_W'(bh);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        bound_writes += 2;
    endtask

    // Mostly small boxes, some wide or tall ones, a few zero or oversized;
    // a quarter of the keys repeat an earlier one
    task automatic send_random(input int unsigned span);
        logic [arp_pkg::HASH_W-1:0] key;
        int unsigned                w;
        int unsigned                h;
        int unsigned                pick;
        if ($urandom_range(99) < 25 && seen_keys.size() != 0)
            key = seen_keys[$urandom_range(seen_keys.size() - 1)];
        else
            key = $urandom();
        pick = $urandom_range(99);
        if (pick < 80) begin
            w = $urandom_range(span, 1);
            h = $urandom_range(span, 1);
        end
        else if (pick < 88) begin
            w = $urandom_range(4096, 1);
            h = $urandom_range(64, 1);
        end
        else if (pick < 96) begin
            w = $urandom_range(64, 1);
            h = $urandom_range(4096, 1);
        end
        else begin
            w = $urandom_range(span, 1);
            h = $urandom_range(span, 1);
            case ($urandom_range(3))
                0:       w = 0;
                1:       h = 0;
                2:       w = $urandom_range(8191, 4097);
                default: h = $urandom_range(8191, 4097);
            endcase
        end
        send_request(key, w, h);
    endtask

    // Settle, set the bounds, then stream random requests
    task automatic run_phase(input int idle_pct, input int unsigned bw, input int unsigned bh,
                             input int unsigned span);
        wait_for_quiet();
        set_bounds(bw, bh);
        send_idle_pct = idle_pct;
        repeat (ITEMS_PER_PHASE)
            send_random(span);
    endtask

    initial begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        key_hash      <= '0;
        rect_width    <= '0;
        rect_height   <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= arp_pkg::REG_ATLAS_WIDTH;
        cfg_data      <= '0;
        send_idle_pct = 19;
        requests_sent = 0;
        bound_writes  = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Default bounds: first placement, no fit, reuse, drop to next row
        send_request(32'h0000_0000, 1, 1);
        send_request(32'hFFFF_FFFF, 4096, 4096);
        send_request(32'h0000_0000, 300, 300);
        send_request(32'h0000_0001, 2048, 1);
        // Zero and oversized boxes, then two that fit
        send_request(32'h0000_0002, 0, 5);
        send_request(32'h0000_0003, 5, 0);
        send_request(32'h0000_0004, 4097, 5);
        send_request(32'h0000_0005, 5, 8191);
        send_request(32'h0000_0006, 8191, 8191);
        send_request(32'hAAAA_AAAA, 100, 50);
        send_request(32'h5555_5555, 5, 5);

        // Zero width leaves no room
        wait_for_quiet();
        set_bounds(0, 2048);
        send_request(32'h0000_0007, 1, 1);

        // Bounds above the maximum are clamped
        wait_for_quiet();
        set_bounds(8191, 8191);
        send_request(32'h0000_0008, 4096, 1);
        send_request(32'h0000_0009, 4096, 4096);

        // Smallest bounds
        wait_for_quiet();
        set_bounds(1, 1);
        send_request(32'h0000_000A, 1, 1);

        // Row overruns the right bound with nothing to step down past
        wait_for_quiet();
        set_bounds(10, 4096);
        send_request(32'h0000_000B, 11, 1);
        send_request(32'h0000_000C, 10, 3);

        // Zero height leaves no room
        wait_for_quiet();
        set_bounds(10, 0);
        send_request(32'h0000_000D, 1, 1);

        // Full-size bounds, a previously refused key, then a reuse
        wait_for_quiet();
        set_bounds(4096, 4096);
        send_request(32'hFFFF_FFFF, 1, 4096);
        send_request(32'h0000_000C, 1, 1);

        // Random phases: sender gaps seldom, then often, then never
        run_phase(19, $urandom_range(1024, 256), $urandom_range(1024, 256), 96);
        run_phase(79, 8191, 8191, 256);
        run_phase(0, $urandom_range(4096, 1), $urandom_range(4096, 1), 128);

        // Drain and let the block idle before the verdict
        wait_for_quiet();
        repeat (4 * arp_pkg::MAX_ENTRIES)
            @(posedge clk);

        $display("covered %0d requests and %0d bound writes over three gap settings",
                 requests_sent, bound_writes);
        $display("results: %0d placed, %0d reused, %0d no room, %0d table full",
                 n_placed, n_reused, n_no_room, n_full);
        if (mismatch_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
